// ===== sv/weighted_cdf_sampler_defines.svh =====
// Assertion macros used by the checker file of the weighted CDF sampler.
`ifndef WEIGHTED_CDF_SAMPLER_DEFINES_SVH
`define WEIGHTED_CDF_SAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define WCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define WCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wcs_pkg.sv =====
// Package with sizes, opcodes and status codes of the weighted CDF sampler.
`timescale 1ns / 1ps

package wcs_pkg;

  // Table and arithmetic sizes.
  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SUM_W       = 42;
  localparam int WGT_W       = 32;
  localparam int RAND_W      = 24;
  localparam int NUM_W       = RAND_W + 1;
  localparam int FRAC_BITS   = 24;
  localparam int PROB_W      = FRAC_BITS + 1;
  localparam int REM_W       = SUM_W + 1;
  localparam int CMP_W       = SUM_W + RAND_W + 1;
  localparam int HALF_W      = SUM_W / 2;
  localparam int PART_W      = (SUM_W - HALF_W) + NUM_W;
  localparam int DCNT_W      = $clog2(FRAC_BITS + 1);

  // Stream widths.
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 48;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 2;

  // Opcodes carried in in_tuser.
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_PROB   = 2'd2;

  // Status codes carried in out_tuser.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

// ===== sv/wcs_ram.sv =====
// Generic single-port RAM with a registered read port.
`timescale 1ns / 1ps

module wcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write or one read per cycle; read data is registered and appears in the next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/weighted_cdf_sampler.sv =====
// Top level of the weighted CDF sampler: prefix-sum table, binary search, serial divider.
//
//   channel   dir  tdata fields (low bit up)                                tuser
//   in_       in   first_entry, weight_value, random_bits, query_index      opcode
//   out_      out  selected_index, probability, entry_count                 status
//
// A load writes its sum to the table RAM in the cycle of its accept.
// A draw forms total*(r+1) in S_MUL0 and S_MUL1, then searches: each search step is
// one table RAM read in S_SREAD and one compare of prefix sum*(2^24+1) against total*(r+1).
// A probability query reads sums in S_QCUR and S_QPREV (skipped for entry zero) and divides.
// Items enter once S_DONE passes on a result. Reset clears state, count, total and out_tvalid.
// A result waiting in the output register does not stop the next item from entering.
`timescale 1ns / 1ps

module weighted_cdf_sampler
  import wcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // first_entry[0], weight_value[32:1], random_bits[56:33], query_index[66:57], zeros
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // selected_index[9:0], probability[34:10], entry_count[45:35], zeros
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]     out_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_DONE, S_MUL0, S_MUL1, S_SREAD, S_SCMP, S_QCUR, S_QPREV, S_QDIV, S_QRND
  } state_t;

  // Input fields.
  logic                     in_first;
  logic signed [WGT_W-1:0]  in_weight;
  logic [RAND_W-1:0]        in_rand;
  logic [IDX_W-1:0]         in_qidx;
  logic                     in_acc;

  assign in_first  = in_tdata[0];
  assign in_weight = in_tdata[WGT_W:1];
  assign in_rand   = in_tdata[WGT_W+RAND_W:WGT_W+1];
  assign in_qidx   = in_tdata[WGT_W+RAND_W+IDX_W:WGT_W+RAND_W+1];
  assign in_acc    = in_tvalid && in_tready;

  // Registers and their next values.
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SUM_W-1:0]     total_r, total_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [IDX_W-1:0]     mid_r, mid_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [PART_W-1:0]    plo_r, plo_nxt;
  logic [CMP_W-1:0]     tprod_r, tprod_nxt;
  logic [SUM_W-1:0]     cur_r, cur_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [PROB_W-1:0]    q_r, q_nxt;
  logic [DCNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic [STAT_W-1:0]    res_stat_r, res_stat_nxt;
  logic [IDX_W-1:0]     res_sel_r, res_sel_nxt;
  logic [PROB_W-1:0]    res_prob_r, res_prob_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0]    out_user_r, out_user_nxt;

  // Table RAM port.
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_addr;
  logic [SUM_W-1:0]     ram_wdata;
  logic [SUM_W-1:0]     ram_rdata;

  wcs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Load arithmetic: clamp the weight, restart on first_entry, saturate the sum.
  logic [SUM_W-1:0]     wv;
  logic [CNT_W-1:0]     cnt_eff;
  logic [SUM_W-1:0]     tot_eff;
  logic [SUM_W:0]       sum_raw;
  logic [SUM_W-1:0]     sum_sat;

  always_comb begin
    wv      = (in_weight > 0) ? SUM_W'(unsigned'(in_weight)) : '0;
    cnt_eff = in_first ? '0 : count_r;
    tot_eff = in_first ? '0 : total_r;
    sum_raw = {1'b0, tot_eff} + {1'b0, wv};
    sum_sat = sum_raw[SUM_W] ? '1 : sum_raw[SUM_W-1:0];
  end

  // Search step: midpoint and exact compare S*(2^RAND_W+1) > total*(r+1).
  logic [CNT_W-1:0]     mid_full;
  logic [CMP_W-1:0]     lhs;
  logic                 above;

  always_comb begin
    mid_full = lo_r + ((hi_r - lo_r) >> 1);
    lhs      = {1'b0, ram_rdata, {RAND_W{1'b0}}} + CMP_W'(ram_rdata);
    above    = lhs > tprod_r;
  end

  // Divider step and final rounding.
  logic [REM_W-1:0]     div_t;
  logic                 div_ge;
  logic [REM_W-1:0]     rnd_t;
  logic [PROB_W:0]      q_rnd;
  logic [PROB_W-1:0]    prob_sat;

  always_comb begin
    div_t    = (dcnt_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    div_ge   = div_t >= {1'b0, total_r};
    rnd_t    = {rem_r[REM_W-2:0], 1'b0};
    q_rnd    = {1'b0, q_r} + (PROB_W+1)'(rnd_t >= {1'b0, total_r});
    prob_sat = (q_rnd > (PROB_W+1)'(1 << FRAC_BITS)) ? PROB_W'(1 << FRAC_BITS)
                                                     : q_rnd[PROB_W-1:0];
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    num_nxt       = num_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    plo_nxt       = plo_r;
    tprod_nxt     = tprod_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    res_stat_nxt  = res_stat_r;
    res_sel_nxt   = res_sel_r;
    res_prob_nxt  = res_prob_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    ram_we        = 1'b0;
    ram_addr      = count_r[IDX_W-1:0];
    ram_wdata     = sum_sat;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_stat_nxt = ST_OK;
          res_sel_nxt  = '0;
          res_prob_nxt = '0;
          state_nxt    = S_DONE;
          unique case (in_tuser)
            OP_LOAD: begin
              count_nxt = cnt_eff;
              total_nxt = tot_eff;
              if (cnt_eff == CNT_W'(MAX_ENTRIES)) begin
                res_stat_nxt = ST_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_addr  = cnt_eff[IDX_W-1:0];
                total_nxt = sum_sat;
                count_nxt = cnt_eff + 1'b1;
              end
            end
            OP_SAMPLE: begin
              if (count_r == '0 || total_r == '0) begin
                res_stat_nxt = ST_EMPTY;
              end else begin
                num_nxt   = NUM_W'(in_rand) + 1'b1;
                lo_nxt    = '0;
                hi_nxt    = count_r;
                state_nxt = S_MUL0;
              end
            end
            OP_PROB: begin
              if (count_r == '0 || total_r == '0) begin
                res_stat_nxt = ST_EMPTY;
              end else if ({1'b0, in_qidx} >= count_r) begin
                res_stat_nxt = ST_RANGE;
              end else begin
                idx_nxt   = in_qidx;
                ram_addr  = in_qidx;
                state_nxt = S_QCUR;
              end
            end
            default: begin
              res_stat_nxt = ST_RANGE;
            end
          endcase
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_DATA_W-CNT_W-PROB_W-IDX_W){1'b0}},
                           count_r, res_prob_r, res_sel_r};
          out_user_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end

      // Target product total*(r+1), split into two halves of the total.
      S_MUL0: begin
        plo_nxt   = PART_W'(total_r[HALF_W-1:0]) * PART_W'(num_r);
        state_nxt = S_MUL1;
      end

      S_MUL1: begin
        tprod_nxt = {PART_W'(total_r[SUM_W-1:HALF_W]) * PART_W'(num_r), {HALF_W{1'b0}}}
                    + CMP_W'(plo_r);
        state_nxt = S_SREAD;
      end

      // Issue the read of the midpoint, or finish when the range is empty.
      S_SREAD: begin
        if (lo_r < hi_r) begin
          ram_addr  = mid_full[IDX_W-1:0];
          mid_nxt   = mid_full[IDX_W-1:0];
          state_nxt = S_SCMP;
        end else begin
          if (lo_r >= count_r) begin
            res_stat_nxt = ST_RANGE;
          end else begin
            res_sel_nxt = lo_r[IDX_W-1:0];
          end
          state_nxt = S_DONE;
        end
      end

      // Narrow the search range with the prefix sum just read.
      S_SCMP: begin
        if (above) begin
          hi_nxt = {1'b0, mid_r};
        end else begin
          lo_nxt = {1'b0, mid_r} + 1'b1;
        end
        state_nxt = S_SREAD;
      end

      // Prefix sum of the queried entry; fetch the one before it if any.
      S_QCUR: begin
        cur_nxt  = ram_rdata;
        q_nxt    = '0;
        dcnt_nxt = '0;
        if (idx_r == '0) begin
          rem_nxt   = REM_W'(ram_rdata);
          state_nxt = S_QDIV;
        end else begin
          ram_addr  = idx_r - 1'b1;
          state_nxt = S_QPREV;
        end
      end

      S_QPREV: begin
        rem_nxt   = REM_W'(cur_r - ram_rdata);
        state_nxt = S_QDIV;
      end

      // Restoring division, one quotient bit per cycle.
      S_QDIV: begin
        rem_nxt = div_ge ? (div_t - {1'b0, total_r}) : div_t;
        q_nxt   = {q_r[PROB_W-2:0], div_ge};
        if (dcnt_r == DCNT_W'(FRAC_BITS)) begin
          state_nxt = S_QRND;
        end else begin
          dcnt_nxt = dcnt_r + 1'b1;
        end
      end

      // Round half up and cap at one.
      S_QRND: begin
        res_prob_nxt = prob_sat;
        state_nxt    = S_DONE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state, table bookkeeping and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // Working registers of the search and the divider.
  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    idx_r      <= idx_nxt;
    plo_r      <= plo_nxt;
    tprod_r    <= tprod_nxt;
    cur_r      <= cur_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    dcnt_r     <= dcnt_nxt;
    res_stat_r <= res_stat_nxt;
    res_sel_r  <= res_sel_nxt;
    res_prob_r <= res_prob_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sv/wcs_checker.sv =====
// Port checker of the weighted CDF sampler and its bind to the top level.
`timescale 1ns / 1ps
`include "weighted_cdf_sampler_defines.svh"

module wcs_checker
  import wcs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser
);

  // Views of the result port used below.
  logic                         out_err;
  logic                         out_stall;
  logic [CNT_W-1:0]             out_count;
  logic [STAT_W+OUT_DATA_W-1:0] out_word;

  assign out_err   = out_tvalid && (out_tuser != ST_OK);
  assign out_stall = out_tvalid && !out_tready;
  assign out_count = out_tdata[45:35];
  assign out_word  = {out_tuser, out_tdata};

  // The block works on one item at a time, so it is busy right after an accept.
  `WCS_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")

  // A failed item reports neither an index nor a probability.
  `WCS_ASSERT_IMP(a_fail_zero_fields, out_err, out_tdata[34:0] == '0, "error result with data")

  // The reported count never goes past the table size.
  `WCS_ASSERT_IMP(a_count_bound, out_tvalid, out_count <= CNT_W'(MAX_ENTRIES), "count too large")

  // A stalled result stays put.
  `WCS_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "stalled result changed")

endmodule

bind weighted_cdf_sampler wcs_checker u_wcs_checker (.*);

// ===== bench/weighted_cdf_sampler_tb.sv =====
// Self-checking testbench for the weighted CDF sampler: loads, draws and probability queries.
`timescale 1ns / 1ps

module weighted_cdf_sampler_tb;
  import wcs_pkg::*;

  // Opcode value that the block must reject.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int IN_USED_W      = 1 + WGT_W + RAND_W + IDX_W;
  localparam int WIDE_W         = CMP_W + 1;
  localparam int QUO_W          = SUM_W + FRAC_BITS + 3;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int ITEMS_BEFORE   = 100;
  localparam int ITEMS_AFTER    = 50;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic              first_entry;
    logic [WGT_W-1:0]  weight_value;
    logic [RAND_W-1:0] random_bits;
    logic [IDX_W-1:0]  query_index;
  } sampler_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  selected_index;
    logic [PROB_W-1:0] probability;
    logic [CNT_W-1:0]  entry_count;
  } sampler_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  weighted_cdf_sampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // Predicted table contents, kept in step with accepted items.
  logic [SUM_W-1:0] tbl_sums [MAX_ENTRIES];
  logic [SUM_W-1:0] tbl_total = '0;
  int               tbl_count = 0;

  sampler_item_t   pending_items [$];
  sampler_result_t expected_results [$];
  sampler_item_t   driven_item;

  // Stimulus generation and bookkeeping.
  int gen_count        = 0;
  int directed_items   = 0;
  int src_burst_left   = 0;
  int src_gap_left     = 0;
  int sink_mode        = 0;
  int sink_phase_left  = 0;
  int idle_cycles      = 0;
  int mismatch_count   = 0;
  int results_checked  = 0;
  int largest_table    = 0;
  int ops_sent [4]     = '{default: 0};
  int status_seen [4]  = '{default: 0};

  // Applies one item to the predicted table and returns the result it must produce.
  function automatic sampler_result_t predict_item(input sampler_item_t it);
    sampler_result_t                res;
    logic [SUM_W-1:0]               wv;
    logic [SUM_W-1:0]               wt;
    logic [SUM_W:0]                 acc;
    logic [WIDE_W-1:0]              lhs, rhs, scale, rnum;
    logic [QUO_W-1:0]               num, den, quo;
    int                             lo, hi, mid;
    res = '0;
    case (it.opcode)
      OP_LOAD: begin
        if (it.first_entry) begin
          tbl_count = 0;
          tbl_total = '0;
        end
        if (tbl_count >= MAX_ENTRIES) begin
          res.status = ST_RANGE;
        end else begin
          // Weights with the sign bit set count as zero; the total saturates.
          wv = it.weight_value[WGT_W-1] ? '0 : SUM_W'(it.weight_value);
          acc = {1'b0, tbl_total} + {1'b0, wv};
          tbl_total = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
          tbl_sums[tbl_count] = tbl_total;
          tbl_count++;
        end
      end
      OP_SAMPLE: begin
        if (tbl_count == 0 || tbl_total == '0) begin
          res.status = ST_EMPTY;
        end else begin
          // First index whose prefix sum S satisfies S*(2^24+1) > total*(r+1).
          rnum = WIDE_W'(it.random_bits) + WIDE_W'(1);
          rhs = WIDE_W'(tbl_total);
          rhs = rhs * rnum;
          scale = WIDE_W'((1 << RAND_W) + 1);
          lo = 0;
          hi = tbl_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            lhs = WIDE_W'(tbl_sums[mid]);
            if (lhs * scale > rhs) hi = mid;
            else lo = mid + 1;
          end
          if (lo >= tbl_count) res.status = ST_RANGE;
          else res.selected_index = IDX_W'(lo);
        end
      end
      OP_PROB: begin
        if (tbl_count == 0 || tbl_total == '0) begin
          res.status = ST_EMPTY;
        end else if (it.query_index >= tbl_count) begin
          res.status = ST_RANGE;
        end else begin
          wt = tbl_sums[it.query_index];
          if (it.query_index != 0) wt = wt - tbl_sums[it.query_index - 1];
          // Rounded to nearest, halves up: floor((wt*2^25 + total) / (2*total)).
          num = QUO_W'(wt);
          num = (num << (FRAC_BITS + 1)) + QUO_W'(tbl_total);
          den = QUO_W'(tbl_total);
          den = den << 1;
          quo = num / den;
          if (quo > QUO_W'(1 << FRAC_BITS)) quo = QUO_W'(1 << FRAC_BITS);
          res.probability = quo[PROB_W-1:0];
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    res.entry_count = CNT_W'(tbl_count);
    return res;
  endfunction

  task automatic queue_item(input logic [OP_W-1:0] op, input logic first,
                            input logic [WGT_W-1:0] wgt, input logic [RAND_W-1:0] rnd,
                            input logic [IDX_W-1:0] qidx);
    sampler_item_t it;
    it.opcode       = op;
    it.first_entry  = first;
    it.weight_value = wgt;
    it.random_bits  = rnd;
    it.query_index  = qidx;
    pending_items = {pending_items, it};
    // Track the table size so that queries can aim near its end.
    if (op == OP_LOAD) begin
      if (first) gen_count = 0;
      if (gen_count < MAX_ENTRIES) gen_count++;
    end
  endtask

  task automatic queue_load(input logic first, input logic [WGT_W-1:0] wgt);
    queue_item(OP_LOAD, first, wgt, RAND_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic queue_draw(input logic [RAND_W-1:0] rnd);
    queue_item(OP_SAMPLE, 1'b0, $urandom, rnd, IDX_W'($urandom));
  endtask

  task automatic queue_query(input logic [IDX_W-1:0] qidx);
    queue_item(OP_PROB, 1'b0, $urandom, RAND_W'($urandom), qidx);
  endtask

  function automatic logic [WGT_W-1:0] pick_weight(input bit heavy);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h8000_0000 | $urandom;
      2:       return 32'h7FFF_FFFF;
      3, 4:    return $urandom_range(1, 16);
      5:       return $urandom_range(1, 65535);
      6:       return $urandom;
      default: return heavy ? (32'h4000_0000 | ($urandom & 32'h3FFF_FFFF))
                            : ($urandom & 32'h7FFF_FFFF);
    endcase
  endfunction

  function automatic logic [RAND_W-1:0] pick_random_bits();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return RAND_W'($urandom_range(0, 15));
      3:       return RAND_W'(24'hFF_FFFF - $urandom_range(0, 15));
      default: return RAND_W'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_query_index();
    if (gen_count > 0 && $urandom_range(0, 9) < 8)
      return IDX_W'($urandom_range(0, gen_count - 1));
    if (gen_count < MAX_ENTRIES && $urandom_range(0, 1)) return IDX_W'(gen_count);
    return IDX_W'($urandom);
  endfunction

  // A freshly started table followed by draws, queries and a few appends.
  task automatic queue_small_table();
    int               n_loads, n_ops;
    bit               zero_table, heavy;
    logic [WGT_W-1:0] wgt;
    n_loads    = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    n_ops      = $urandom_range(3, 20);
    zero_table = ($urandom_range(0, 9) == 0);
    heavy      = 1'($urandom_range(0, 1));
    for (int i = 0; i < n_loads; i++) begin
      if (zero_table) wgt = $urandom_range(0, 1) ? 32'h0 : (32'h8000_0000 | $urandom);
      else wgt = pick_weight(heavy);
      queue_load(i == 0, wgt);
    end
    for (int i = 0; i < n_ops; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: queue_draw(pick_random_bits());
        5, 6, 7:       queue_query(pick_query_index());
        8:             queue_load(1'b0, pick_weight(heavy));
        default:       queue_item($urandom_range(0, 1) ? OP_SAMPLE : OP_PROB, 1'b1,
                                  $urandom, pick_random_bits(), pick_query_index());
      endcase
    end
  endtask

  // A few items with every field random, opcode included.
  task automatic queue_noise();
    repeat ($urandom_range(1, 6))
      queue_item(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
                 RAND_W'($urandom), IDX_W'($urandom));
  endtask

  // Fills the table to capacity, overfills it, then restarts it.
  task automatic queue_full_table();
    queue_load(1'b1, pick_weight(1'b1));
    while (gen_count < MAX_ENTRIES) queue_load(1'b0, pick_weight(1'b1));
    repeat (3) queue_load(1'b0, pick_weight(1'b0));
    repeat (40) begin
      if ($urandom_range(0, 1)) queue_draw(pick_random_bits());
      else queue_query(pick_query_index());
    end
    queue_query(10'h3FF);
    queue_draw('1);
    queue_draw('0);
    queue_load(1'b0, 32'h7FFF_FFFF);
    queue_load(1'b1, pick_weight(1'b0));
    queue_draw(pick_random_bits());
  endtask

  // Source side: drives pending items in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results = {expected_results, predict_item(driven_item)};
        ops_sent[driven_item.opcode]++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap_left > 0) begin
          src_gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          driven_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= driven_item.opcode;
          in_tdata  <= {{(IN_DATA_W - IN_USED_W){1'b0}}, driven_item.query_index,
                        driven_item.random_bits, driven_item.weight_value,
                        driven_item.first_entry};
          if (src_burst_left > 1) begin
            src_burst_left--;
          end else begin
            src_burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 12);
            src_gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: ready follows a random mode, redrawn when its phase runs out.
  always @(posedge clk) begin
    if (sink_phase_left == 0) begin
      sink_mode       = $urandom_range(0, 3);
      sink_phase_left = $urandom_range(16, 160);
    end else begin
      sink_phase_left--;
    end
    case (sink_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 5) == 0);
      default: out_tready <= (sink_phase_left % 12) < 4;
    endcase
  end

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    sampler_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status         = out_tuser;
      got.selected_index = out_tdata[IDX_W-1:0];
      got.probability    = out_tdata[IDX_W+PROB_W-1:IDX_W];
      got.entry_count    = out_tdata[IDX_W+PROB_W+CNT_W-1:IDX_W+PROB_W];
      results_checked++;
      status_seen[got.status]++;
      if (int'(got.entry_count) > largest_table) largest_table = int'(got.entry_count);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: result %0d arrived with no item outstanding: status %0d idx %0d",
                   results_checked, got.status, got.selected_index);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"ERROR: result %0d: expected status %0d idx %0d prob %0d count %0d,",
                      " got status %0d idx %0d prob %0d count %0d"}, results_checked,
                     want.status, want.selected_index, want.probability, want.entry_count,
                     got.status, got.selected_index, got.probability, got.entry_count);
        end
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    // Empty table, zero total and rejected opcode.
    queue_draw('0);
    queue_query('0);
    queue_item(OP_UNUSED, 1'b1, '1, '1, '1);
    queue_load(1'b1, 32'h0);
    queue_load(1'b0, 32'h8000_0000);
    queue_draw('1);
    queue_query('0);
    // Restart with extreme weights, including a zero-weight entry.
    queue_load(1'b1, 32'h7FFF_FFFF);
    queue_load(1'b0, 32'h1);
    queue_load(1'b0, 32'h0);
    queue_load(1'b0, 32'hFFFF_FFFF);
    queue_load(1'b0, 32'h7FFF_FFFF);
    queue_draw('0);
    queue_draw('1);
    queue_draw(24'h80_0000);
    queue_query(10'd0);
    queue_query(10'd1);
    queue_query(10'd2);
    queue_query(10'd5);
    queue_query(10'h3FF);
    // The first-entry flag must be ignored on draws and queries.
    queue_item(OP_SAMPLE, 1'b1, '1, 24'h00_0001, '0);
    queue_item(OP_PROB, 1'b1, '1, '0, 10'd4);
    // A single entry holds the whole probability.
    queue_load(1'b1, 32'h1);
    queue_query(10'd0);
    queue_draw('1);
    directed_items = pending_items.size();

    // Mostly well-formed tables with random content, some noise in between.
    while (pending_items.size() < directed_items + ITEMS_BEFORE) begin
      if ($urandom_range(0, 9) < 8) queue_small_table();
      else queue_noise();
    end
    queue_full_table();
    directed_items = pending_items.size();
    while (pending_items.size() < directed_items + ITEMS_AFTER) begin
      if ($urandom_range(0, 9) < 8) queue_small_table();
      else queue_noise();
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every result to come back.
    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d loads, %0d draws, %0d probability queries, %0d rejected opcodes.",
             ops_sent[OP_LOAD], ops_sent[OP_SAMPLE], ops_sent[OP_PROB], ops_sent[OP_UNUSED]);
    $display("Checked %0d results: %0d ok, %0d empty, %0d out of range; largest table %0d.",
             results_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
             status_seen[ST_RANGE], largest_table);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
